### rtl/indexed_doubly_linked_list_defines.svh
// assertion helpers for the rtl
`ifndef INDEXED_DOUBLY_LINKED_LIST_DEFINES_SVH
`define INDEXED_DOUBLY_LINKED_LIST_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define IDLL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("idll assertion failed");

// next-cycle implication, disabled while reset is low
`define IDLL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("idll assertion failed");

`endif

### rtl/idll_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package idll_pkg;

    localparam int CMD_W       = 3;
    localparam int SLOT_W      = 8;
    localparam int CNT_W       = 9;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 40;

    localparam logic [CNT_W-1:0] CAP_RESET = 9'd256;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_REMOVE     = 3'd4,
        CMD_CONTAINS   = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_DONE     = 2'd0,
        STAT_RANGE    = 2'd1,
        STAT_PRESENCE = 2'd2,
        STAT_EMPTY    = 2'd3
    } t_status;

    // result word, status in the lowest bits
    typedef struct packed {
        logic              list_empty;
        logic [CNT_W-1:0]  entry_count;
        logic              tail_valid;
        logic [SLOT_W-1:0] tail_slot;
        logic              head_valid;
        logic [SLOT_W-1:0] head_slot;
        logic              is_member;
        logic              popped_valid;
        logic [SLOT_W-1:0] popped_index;
        t_status           status;
    } t_result;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic clear;
        logic update;
    } t_ctrl;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

### rtl/idll_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module idll_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s_tvalid,
    input  wire idll_pkg::t_dp_stat i_stat,
    output logic                    o_ready,
    output idll_pkg::t_ctrl         o_ctrl
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_UPDATE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ready;

    always_comb begin
        o_ctrl.accept = r_ready && i_s_tvalid;
        o_ctrl.clear  = (r_state == ST_CLEAR);
        o_ctrl.update = (r_state == ST_UPDATE) && i_stat.out_free;
        n_state       = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_stat.clear_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (o_ctrl.accept) n_state = ST_READ;
            end
            ST_READ: begin
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (i_stat.out_free) n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == ST_IDLE);
        end
    end

    assign o_ready = r_ready;

endmodule

`default_nettype wire

### rtl/idll_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module idll_dp #(
    parameter int MAX_SLOTS = 256
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire idll_pkg::t_ctrl                    i_ctrl,
    input  wire logic [idll_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    input  wire logic                               i_cfg_we,
    input  wire logic [idll_pkg::CNT_W-1:0]         i_cfg_wdata,
    input  wire logic                               i_m_tready,
    output idll_pkg::t_dp_stat                      o_stat,
    output logic                                    o_m_tvalid,
    output idll_pkg::t_result                       o_m_tdata
);

    localparam int AW = $clog2(MAX_SLOTS);
    localparam int LW = $clog2(MAX_SLOTS + 1);
    localparam int IW = (AW > idll_pkg::SLOT_W) ? AW : idll_pkg::SLOT_W;
    localparam int OW = (LW > idll_pkg::SLOT_W) ? LW : idll_pkg::SLOT_W;
    localparam logic [LW-1:0] NONE = LW'(MAX_SLOTS);

    // link memories and active marks
    logic [AW-1:0] prev_mem [MAX_SLOTS];
    logic [AW-1:0] next_mem [MAX_SLOTS];
    logic          act_mem  [MAX_SLOTS];

    logic [AW-1:0] r_prev_rd;
    logic [AW-1:0] r_next_rd;
    logic          r_act_rd;

    logic [idll_pkg::CNT_W-1:0]  r_cap;
    idll_pkg::t_cmd              r_cmd;
    logic [idll_pkg::SLOT_W-1:0] r_slot;
    logic [LW-1:0]               r_head;
    logic [LW-1:0]               r_tail;
    logic [idll_pkg::CNT_W-1:0]  r_len;
    logic [AW-1:0]               r_clr_cnt;
    logic                        r_out_valid;
    idll_pkg::t_result           r_out;

    logic [IW-1:0]              slot_w;
    logic [AW-1:0]              rd_addr;
    logic [LW-1:0]              tgt;
    logic [LW-1:0]              vict;
    logic                       vict_ok;
    logic                       in_range;
    logic [LW-1:0]              lnk_p;
    logic [LW-1:0]              lnk_n;
    logic                       do_unlink;
    logic                       out_free;

    logic [LW-1:0]              n_head;
    logic [LW-1:0]              n_tail;
    logic [idll_pkg::CNT_W-1:0] n_len;
    idll_pkg::t_result          n_out;
    logic [OW-1:0]              head_ow;
    logic [OW-1:0]              tail_ow;
    logic [OW-1:0]              vict_ow;

    logic          prev_we, next_we, act_we;
    logic [AW-1:0] prev_wa, next_wa, act_wa;
    logic [AW-1:0] prev_wd, next_wd;
    logic          act_wd;

    assign slot_w   = IW'(r_slot);
    assign out_free = !r_out_valid || i_m_tready;
    assign in_range = ({1'b0, r_slot} < r_cap) && (32'(r_slot) < 32'(MAX_SLOTS));
    assign vict     = (r_cmd == idll_pkg::CMD_POP_FRONT) ? r_head : r_tail;
    assign vict_ok  = (vict != NONE);

    always_comb begin
        case (r_cmd)
            idll_pkg::CMD_POP_FRONT: rd_addr = r_head[AW-1:0];
            idll_pkg::CMD_POP_BACK:  rd_addr = r_tail[AW-1:0];
            default:                 rd_addr = slot_w[AW-1:0];
        endcase
    end

    // neighbors of the slot being unlinked, ends of the list read as none
    assign tgt   = LW'(rd_addr);
    assign lnk_p = (tgt == r_head) ? NONE : LW'(r_prev_rd);
    assign lnk_n = (tgt == r_tail) ? NONE : LW'(r_next_rd);

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_len   = r_len;
        prev_we = 1'b0;
        next_we = 1'b0;
        act_we  = 1'b0;
        prev_wa = rd_addr;
        next_wa = rd_addr;
        act_wa  = rd_addr;
        prev_wd = '0;
        next_wd = '0;
        act_wd  = 1'b0;
        do_unlink = 1'b0;
        n_out   = '0;
        n_out.status = idll_pkg::STAT_DONE;

        unique case (r_cmd) inside
            idll_pkg::CMD_PUSH_BACK: begin
                if (!in_range) begin
                    n_out.status = idll_pkg::STAT_RANGE;
                end else if (r_act_rd) begin
                    n_out.status = idll_pkg::STAT_PRESENCE;
                end else begin
                    act_we  = 1'b1;
                    act_wd  = 1'b1;
                    prev_we = 1'b1;
                    prev_wd = r_tail[AW-1:0];
                    if (r_tail != NONE) begin
                        next_we = 1'b1;
                        next_wa = r_tail[AW-1:0];
                        next_wd = rd_addr;
                    end else begin
                        n_head = tgt;
                    end
                    n_tail = tgt;
                    n_len  = r_len + 1'b1;
                end
            end
            idll_pkg::CMD_PUSH_FRONT: begin
                if (!in_range) begin
                    n_out.status = idll_pkg::STAT_RANGE;
                end else if (r_act_rd) begin
                    n_out.status = idll_pkg::STAT_PRESENCE;
                end else begin
                    act_we  = 1'b1;
                    act_wd  = 1'b1;
                    next_we = 1'b1;
                    next_wd = r_head[AW-1:0];
                    if (r_head != NONE) begin
                        prev_we = 1'b1;
                        prev_wa = r_head[AW-1:0];
                        prev_wd = rd_addr;
                    end else begin
                        n_tail = tgt;
                    end
                    n_head = tgt;
                    n_len  = r_len + 1'b1;
                end
            end
            idll_pkg::CMD_POP_FRONT, idll_pkg::CMD_POP_BACK: begin
                if (!vict_ok) begin
                    n_out.status = idll_pkg::STAT_EMPTY;
                end else begin
                    do_unlink          = 1'b1;
                    n_out.popped_valid = 1'b1;
                end
            end
            idll_pkg::CMD_REMOVE: begin
                if (!in_range) begin
                    n_out.status = idll_pkg::STAT_RANGE;
                end else if (!r_act_rd) begin
                    n_out.status = idll_pkg::STAT_PRESENCE;
                end else begin
                    do_unlink = 1'b1;
                end
            end
            idll_pkg::CMD_CONTAINS: begin
                if (!in_range) n_out.status = idll_pkg::STAT_RANGE;
                else           n_out.is_member = r_act_rd;
            end
            default: begin
            end
        endcase

        if (do_unlink) begin
            act_we = 1'b1;
            act_wd = 1'b0;
            if (lnk_p != NONE) begin
                next_we = 1'b1;
                next_wa = lnk_p[AW-1:0];
                next_wd = lnk_n[AW-1:0];
            end else begin
                n_head = lnk_n;
            end
            if (lnk_n != NONE) begin
                prev_we = 1'b1;
                prev_wa = lnk_n[AW-1:0];
                prev_wd = lnk_p[AW-1:0];
            end else begin
                n_tail = lnk_p;
            end
            n_len = r_len - 1'b1;
        end

        head_ow = OW'(n_head);
        tail_ow = OW'(n_tail);
        vict_ow = OW'(vict);
        n_out.popped_index = n_out.popped_valid ? vict_ow[idll_pkg::SLOT_W-1:0] : '0;
        n_out.head_valid   = (n_head != NONE);
        n_out.head_slot    = n_out.head_valid ? head_ow[idll_pkg::SLOT_W-1:0] : '0;
        n_out.tail_valid   = (n_tail != NONE);
        n_out.tail_slot    = n_out.tail_valid ? tail_ow[idll_pkg::SLOT_W-1:0] : '0;
        n_out.entry_count  = n_len;
        n_out.list_empty   = (n_len == '0);
    end

    // memories: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (i_ctrl.update && prev_we) prev_mem[prev_wa] <= prev_wd;
        r_prev_rd <= prev_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.update && next_we) next_mem[next_wa] <= next_wd;
        r_next_rd <= next_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.clear) begin
            act_mem[r_clr_cnt] <= 1'b0;
        end else if (i_ctrl.update && act_we) begin
            act_mem[act_wa] <= act_wd;
        end
        r_act_rd <= act_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept) begin
            r_cmd  <= idll_pkg::t_cmd'(i_s_tdata[idll_pkg::CMD_W-1:0]);
            r_slot <= i_s_tdata[idll_pkg::CMD_W +: idll_pkg::SLOT_W];
        end
        if (i_ctrl.update) r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= idll_pkg::CAP_RESET;
            r_head      <= NONE;
            r_tail      <= NONE;
            r_len       <= '0;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_cap <= i_cfg_wdata;
            if (i_ctrl.clear) r_clr_cnt <= r_clr_cnt + 1'b1;
            if (i_ctrl.update) begin
                r_head      <= n_head;
                r_tail      <= n_tail;
                r_len       <= n_len;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.clear_last = (r_clr_cnt == AW'(MAX_SLOTS - 1));
    assign o_stat.out_free   = out_free;
    assign o_m_tvalid        = r_out_valid;
    assign o_m_tdata         = r_out;

endmodule

`default_nettype wire

### rtl/indexed_doubly_linked_list.sv
// indexed doubly linked list manager
// each request passes through accept, link read and link update; the update waits while a result is still unread
// a new request is taken only after the previous one has finished its link update
// reset: synchronous active low; afterwards the active marks of all MAX_SLOTS slots are cleared, one slot a cycle,
//   during which no request is taken (capacity writes still land)
`timescale 1ns / 1ps
`default_nettype none
`include "indexed_doubly_linked_list_defines.svh"

module indexed_doubly_linked_list #(
    parameter int MAX_SLOTS = 256
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // request stream
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [2:0] command, [10:3] slot_index, [15:11] zero
    input  wire logic [idll_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // result stream
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // [1:0] status, [9:2] popped_index, [10] popped_valid, [11] is_member,
    // [19:12] head_slot, [20] head_valid, [28:21] tail_slot, [29] tail_valid,
    // [38:30] entry_count, [39] list_empty
    output logic [idll_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // capacity register write
    input  wire logic                             i_cfg_we,
    input  wire logic [idll_pkg::CNT_W-1:0]       i_cfg_wdata
);

    // most slots that can ever be linked: bounded by memory depth and index width
    localparam int CNT_MAX = (MAX_SLOTS < 256) ? MAX_SLOTS : 256;

    idll_pkg::t_ctrl    w_ctrl;
    idll_pkg::t_dp_stat w_stat;
    idll_pkg::t_result  w_res;
    logic               w_accept;

    // sequencer: clear sweep, then accept / read / update per request
    idll_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_stat     (w_stat),
        .o_ready    (s_axis_tready),
        .o_ctrl     (w_ctrl)
    );

    // link memories, head / tail / count and the result register
    idll_dp #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .i_s_tdata   (s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_m_tready  (m_axis_tready),
        .o_stat      (w_stat),
        .o_m_tvalid  (m_axis_tvalid),
        .o_m_tdata   (w_res)
    );

    assign m_axis_tdata = w_res;
    assign w_accept     = s_axis_tvalid && s_axis_tready;

    // a taken request closes the input until its result is built
    `IDLL_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_accept, !s_axis_tready)

    // head and tail exist exactly when the list is not empty
    `IDLL_ASSERT_NOW(a_ends_match_count, i_clk, i_rst_n, m_axis_tvalid,
        (w_res.head_valid == !w_res.list_empty) && (w_res.tail_valid == !w_res.list_empty))

    // count never passes the number of addressable slots
    `IDLL_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, m_axis_tvalid,
        32'(w_res.entry_count) <= CNT_MAX)

    // a returned slot always comes with a done status
    `IDLL_ASSERT_NOW(a_pop_status, i_clk, i_rst_n, m_axis_tvalid && w_res.popped_valid,
        w_res.status == idll_pkg::STAT_DONE)

endmodule

`default_nettype wire
